// ===== hw/rtl/pngu_pkg.sv =====
// Shared constants and filter codes of the PNG scanline unfilter.
package pngu_pkg;

  localparam int MAX_ROW_BYTES   = 8192;
  localparam int MAX_PIXEL_BYTES = 8;

  localparam int BYTE_W     = 8;
  localparam int KIND_W     = 8;
  localparam int BPP_W      = 4;
  localparam int ROW_BYTES_W = 14;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 14;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_BYTES_PER_PIXEL = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_BYTES       = 1'd1;

  // Row filter codes.
  localparam logic [KIND_W-1:0] FILT_NONE  = 8'd0;
  localparam logic [KIND_W-1:0] FILT_SUB   = 8'd1;
  localparam logic [KIND_W-1:0] FILT_UP    = 8'd2;
  localparam logic [KIND_W-1:0] FILT_AVG   = 8'd3;
  localparam logic [KIND_W-1:0] FILT_PAETH = 8'd4;

  // Paeth predictor on left (a), upper (b) and upper-left (c) bytes.
  function automatic logic [BYTE_W-1:0] paeth(input logic [BYTE_W-1:0] a,
                                               input logic [BYTE_W-1:0] b,
                                               input logic [BYTE_W-1:0] c);
    logic signed [BYTE_W+1:0] da;
    logic signed [BYTE_W+1:0] db;
    logic signed [BYTE_W+1:0] dc;
    da = $signed({2'b00, b}) - $signed({2'b00, c});
    db = $signed({2'b00, a}) - $signed({2'b00, c});
    dc = $signed({2'b00, a}) + $signed({2'b00, b}) - $signed({1'b0, c, 1'b0});
    if (da < 0) da = -da;
    if (db < 0) db = -db;
    if (dc < 0) dc = -dc;
    if (da <= db && da <= dc) return a;
    else if (db <= dc) return b;
    else return c;
  endfunction

endpackage

// ===== hw/rtl/pngu_in_if.sv =====
// Input channel: one filtered byte with its row flags per word.
interface pngu_in_if;
  logic                             valid;
  logic                             ready;
  logic [pngu_pkg::BYTE_W-1:0]      filtered_byte;
  logic [pngu_pkg::KIND_W-1:0]      filter_kind;
  logic                             first_row;

  modport source (output valid, output filtered_byte, output filter_kind,
                  output first_row, input ready);
  modport sink   (input valid, input filtered_byte, input filter_kind,
                  input first_row, output ready);
endinterface

// ===== hw/rtl/pngu_out_if.sv =====
// Result channel: one reconstructed byte and its row end flag per word.
interface pngu_out_if;
  logic                             valid;
  logic                             ready;
  logic [pngu_pkg::BYTE_W-1:0]      recon_byte;
  logic                             row_end;

  modport source (output valid, output recon_byte, output row_end, input ready);
  modport sink   (input valid, input recon_byte, input row_end, output ready);
endinterface

// ===== hw/rtl/pngu_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module pngu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // A read of the entry being written returns the old contents.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== hw/rtl/png_scanline_unfilter_core.sv =====
// PNG scanline unfilter (none, sub, up, average, Paeth), one byte per word.
//
//   channel  | dir | handshake        | payload
//   ---------+-----+------------------+------------------------------------------
//   in_ch    | in  | valid / ready    | filtered_byte[7:0], filter_kind[7:0],
//            |     |                  | first_row
//   out_ch   | out | valid / ready    | recon_byte[7:0], row_end
//   cfg      | in  | cfg_we (no wait) | cfg_index (0 bytes_per_pixel,
//            |     |                  | 1 row_bytes), cfg_wdata[13:0]
//
// Throughput is one word per cycle while out_ch is not stalled. A word accepted
// on in_ch passes through the compute stage registers and then the output
// register on out_ch. The limit is the line store: its read of the upper byte is
// issued when the word is accepted and comes back registered in the compute stage.
// Reset (rst_n, synchronous) empties the pipeline and zeroes the column and the
// pixel history; the line store itself is not cleared and needs no sweep.
// When out_ch stalls, the word in the compute stage holds and re-reads its line
// store entry each cycle; in_ch stays ready as long as that stage can move on.
module png_scanline_unfilter_core #(
  parameter int MAX_ROW_BYTES   = pngu_pkg::MAX_ROW_BYTES,
  parameter int MAX_PIXEL_BYTES = pngu_pkg::MAX_PIXEL_BYTES
) (
  input  logic                                clk,
  input  logic                                rst_n,
  pngu_in_if.sink                             in_ch,
  pngu_out_if.source                          out_ch,
  input  logic                                cfg_we,
  input  logic [pngu_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [pngu_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  localparam int COL_W   = $clog2(MAX_ROW_BYTES);
  localparam int LEN_W   = $clog2(MAX_ROW_BYTES + 1);
  localparam int CMP_W   = (LEN_W > pngu_pkg::ROW_BYTES_W) ? LEN_W : pngu_pkg::ROW_BYTES_W;
  localparam int PIX_IDX_W = (MAX_PIXEL_BYTES > 1) ? $clog2(MAX_PIXEL_BYTES) : 1;
  localparam int BW      = pngu_pkg::BYTE_W;

  // ---------------------------------------------------------------------------
  // Configuration registers.
  // ---------------------------------------------------------------------------
  logic [pngu_pkg::BPP_W-1:0]       bpp_r;
  logic [pngu_pkg::ROW_BYTES_W-1:0] row_bytes_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bpp_r       <= pngu_pkg::BPP_W'(1);
      row_bytes_r <= pngu_pkg::ROW_BYTES_W'(1);
    end else if (cfg_we) begin
      unique case (cfg_index)
        pngu_pkg::REG_BYTES_PER_PIXEL: bpp_r <= cfg_wdata[pngu_pkg::BPP_W-1:0];
        pngu_pkg::REG_ROW_BYTES:       row_bytes_r <= cfg_wdata[pngu_pkg::ROW_BYTES_W-1:0];
        default: ;
      endcase
    end
  end

  // Out-of-range register values are clamped where they are used.
  logic [pngu_pkg::BPP_W-1:0] bpp_sat;
  logic [CMP_W-1:0]           len_sat;
  logic [CMP_W-1:0]           row_ext;
  logic [PIX_IDX_W-1:0]       tap_idx;

  always_comb begin
    if (bpp_r == '0) begin
      bpp_sat = pngu_pkg::BPP_W'(1);
    end else if (32'(bpp_r) > MAX_PIXEL_BYTES) begin
      bpp_sat = pngu_pkg::BPP_W'(MAX_PIXEL_BYTES);
    end else begin
      bpp_sat = bpp_r;
    end
    row_ext = CMP_W'(row_bytes_r);
    if (row_ext == '0) begin
      len_sat = CMP_W'(1);
    end else if (row_ext > CMP_W'(MAX_ROW_BYTES)) begin
      len_sat = CMP_W'(MAX_ROW_BYTES);
    end else begin
      len_sat = row_ext;
    end
  end

  assign tap_idx = PIX_IDX_W'(bpp_sat - pngu_pkg::BPP_W'(1));

  // ---------------------------------------------------------------------------
  // Accept stage: column bookkeeping and line store read issue.
  // ---------------------------------------------------------------------------
  logic [COL_W-1:0] column_r;
  logic [COL_W-1:0] column_nxt;
  logic [COL_W-1:0] acc_col;
  logic [CMP_W-1:0] col_ext;
  logic             acc_last;
  logic             acc_left_ok;
  logic             in_fire;

  always_comb begin
    col_ext = CMP_W'(column_r);
    // A row that was shortened while this column was further on ends here.
    if (col_ext >= len_sat) begin
      col_ext = len_sat - CMP_W'(1);
    end
    acc_col     = COL_W'(col_ext);
    acc_last    = (col_ext + CMP_W'(1)) >= len_sat;
    acc_left_ok = col_ext >= CMP_W'(bpp_sat);
    column_nxt  = acc_last ? '0 : COL_W'(col_ext + CMP_W'(1));
  end

  // ---------------------------------------------------------------------------
  // Compute stage registers.
  // ---------------------------------------------------------------------------
  logic                              s1_valid_r;
  logic [BW-1:0]                     s1_byte_r;
  logic [pngu_pkg::KIND_W-1:0]       s1_kind_r;
  logic                              s1_top_r;
  logic [COL_W-1:0]                  s1_col_r;
  logic                              s1_last_r;
  logic                              s1_left_ok_r;
  logic                              fwd_r;
  logic [BW-1:0]                     fwd_data_r;

  logic out_valid_r;
  logic [BW-1:0] out_recon_r;
  logic out_end_r;

  logic s1_adv;
  assign s1_adv  = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !s1_valid_r || s1_adv;
  assign in_fire = in_ch.valid && in_ch.ready;

  // Line store: a stalled word keeps re-reading its own entry, since nothing
  // is written while it waits.
  logic [COL_W-1:0] ram_raddr;
  logic [BW-1:0]    ram_rdata;
  logic [BW-1:0]    recon;

  assign ram_raddr = (s1_valid_r && !s1_adv) ? s1_col_r : acc_col;

  pngu_ram #(
    .WIDTH (BW),
    .DEPTH (MAX_ROW_BYTES)
  ) u_line_store (
    .clk   (clk),
    .we    (s1_adv),
    .waddr (s1_col_r),
    .wdata (recon),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      fwd_r      <= 1'b0;
      column_r   <= '0;
    end else begin
      if (in_fire) begin
        s1_valid_r <= 1'b1;
        column_r   <= column_nxt;
        // The word leaving now writes the entry this one just read (one-byte
        // rows): the read returned stale data, so take the new byte directly.
        fwd_r      <= s1_adv && (s1_col_r == acc_col);
      end else begin
        if (s1_adv) begin
          s1_valid_r <= 1'b0;
        end
        // Any later re-read already sees the written entry.
        fwd_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_byte_r    <= in_ch.filtered_byte;
      s1_kind_r    <= in_ch.filter_kind;
      s1_top_r     <= in_ch.first_row;
      s1_col_r     <= acc_col;
      s1_last_r    <= acc_last;
      s1_left_ok_r <= acc_left_ok;
    end
    if (s1_adv) begin
      fwd_data_r <= recon;
    end
  end

  // ---------------------------------------------------------------------------
  // Reconstruction.
  // ---------------------------------------------------------------------------
  logic [BW-1:0] left_r  [MAX_PIXEL_BYTES];
  logic [BW-1:0] upper_r [MAX_PIXEL_BYTES];
  logic [BW-1:0] nb_a;
  logic [BW-1:0] nb_b;
  logic [BW-1:0] nb_c;
  logic [BW-1:0] pred;
  logic [BW:0]   avg_sum;

  always_comb begin
    nb_a = s1_left_ok_r ? left_r[tap_idx] : '0;
    if (s1_top_r) begin
      nb_b = '0;
    end else if (fwd_r) begin
      nb_b = fwd_data_r;
    end else begin
      nb_b = ram_rdata;
    end
    nb_c    = (!s1_top_r && s1_left_ok_r) ? upper_r[tap_idx] : '0;
    avg_sum = {1'b0, nb_a} + {1'b0, nb_b};
    case (s1_kind_r)
      pngu_pkg::FILT_SUB:   pred = nb_a;
      pngu_pkg::FILT_UP:    pred = nb_b;
      pngu_pkg::FILT_AVG:   pred = avg_sum[BW:1];
      pngu_pkg::FILT_PAETH: pred = pngu_pkg::paeth(nb_a, nb_b, nb_c);
      default:              pred = '0;
    endcase
    recon = s1_byte_r + pred;
  end

  // Pixel history: recent bytes of this row and of the row above.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < MAX_PIXEL_BYTES; k++) begin
        left_r[k]  <= '0;
        upper_r[k] <= '0;
      end
    end else if (s1_adv) begin
      left_r[0]  <= recon;
      upper_r[0] <= nb_b;
      for (int k = 1; k < MAX_PIXEL_BYTES; k++) begin
        left_r[k]  <= left_r[k-1];
        upper_r[k] <= upper_r[k-1];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Output register.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_recon_r <= recon;
      out_end_r   <= s1_last_r;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.recon_byte = out_recon_r;
  assign out_ch.row_end    = out_end_r;

  // ---------------------------------------------------------------------------
  // Assertions.
  // ---------------------------------------------------------------------------
  // A word stuck behind a full output register keeps its column.
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !s1_adv |=> s1_valid_r && $stable(s1_col_r))
    else $error("compute stage lost its word while stalled");

  // Forwarding only happens for a word that is present in the compute stage.
  a_fwd_valid: assert property (@(posedge clk) disable iff (!rst_n)
    fwd_r |-> s1_valid_r)
    else $error("forward flag set without a word in the compute stage");

  // Accepting the last byte of a row rewinds the column.
  a_row_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && acc_last |=> column_r == '0)
    else $error("column did not return to zero after the row end");

  // A word leaving the compute stage always shows up as a result.
  a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv |=> out_valid_r && out_end_r == $past(s1_last_r))
    else $error("result register did not take the finished word");

endmodule

// ===== dv/pngu_recon_checker.sv =====
// Predicts each reconstructed byte of the unfilter and compares it with the result channel.
module pngu_recon_checker (
  input  logic                              clk,
  input  logic                              rst_n,
  pngu_in_if                                in_mon,
  pngu_out_if                               out_mon,
  input  logic                              cfg_we,
  input  logic [pngu_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [pngu_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  output int                                fail_count,
  output int                                awaited
);
  timeunit 1ns;
  timeprecision 1ps;

  import pngu_pkg::*;

  typedef struct packed {
    logic [BYTE_W-1:0] recon_byte;
    logic              row_end;
  } recon_word_t;

  recon_word_t              recon_fifo[$];
  logic [BYTE_W-1:0]        prior_row [MAX_ROW_BYTES];
  logic [BYTE_W-1:0]        left_hist [MAX_PIXEL_BYTES];
  logic [BYTE_W-1:0]        upper_hist [MAX_PIXEL_BYTES];
  int unsigned              row_pos;
  logic [BPP_W-1:0]         bpp_cfg;
  logic [ROW_BYTES_W-1:0]   row_len_cfg;

  // Reconstructs one byte and advances the row position and pixel history.
  function automatic recon_word_t unfilter_next(input logic [BYTE_W-1:0] x,
                                                input logic [KIND_W-1:0] kind,
                                                input logic              top);
    int unsigned       step;
    int unsigned       len;
    int unsigned       col;
    logic [BYTE_W-1:0] a;
    logic [BYTE_W-1:0] b;
    logic [BYTE_W-1:0] c;
    logic [BYTE_W-1:0] guess;
    int                est;
    int                da;
    int                db;
    int                dc;
    recon_word_t       res;

    step = (bpp_cfg == 0) ? 1 : ((bpp_cfg > MAX_PIXEL_BYTES) ? MAX_PIXEL_BYTES : bpp_cfg);
    len  = (row_len_cfg == 0) ? 1 :
           ((row_len_cfg > MAX_ROW_BYTES) ? MAX_ROW_BYTES : row_len_cfg);
    col  = (row_pos >= len) ? len - 1 : row_pos;

    a = (col >= step) ? left_hist[step-1] : '0;
    b = top ? '0 : prior_row[col];
    c = (!top && col >= step) ? upper_hist[step-1] : '0;

    case (kind)
      FILT_SUB:   guess = a;
      FILT_UP:    guess = b;
      FILT_AVG:   guess = BYTE_W'((int'(a) + int'(b)) >> 1);
      FILT_PAETH: begin
        est = int'(a) + int'(b) - int'(c);
        da  = (est > int'(a)) ? est - int'(a) : int'(a) - est;
        db  = (est > int'(b)) ? est - int'(b) : int'(b) - est;
        dc  = (est > int'(c)) ? est - int'(c) : int'(c) - est;
        if (da <= db && da <= dc) guess = a;
        else if (db <= dc) guess = b;
        else guess = c;
      end
      default:    guess = '0;
    endcase

    res.recon_byte = x + guess;
    prior_row[col] = res.recon_byte;
    for (int k = MAX_PIXEL_BYTES - 1; k > 0; k--) begin
      left_hist[k]  = left_hist[k-1];
      upper_hist[k] = upper_hist[k-1];
    end
    left_hist[0]  = res.recon_byte;
    upper_hist[0] = b;

    res.row_end = (col + 1 >= len);
    row_pos     = res.row_end ? 0 : col + 1;
    return res;
  endfunction

  always @(posedge clk) begin
    recon_word_t want;
    if (!rst_n) begin
      recon_fifo.delete();
      for (int k = 0; k < MAX_PIXEL_BYTES; k++) begin
        left_hist[k]  = '0;
        upper_hist[k] = '0;
      end
      row_pos     = 0;
      bpp_cfg     = 1;
      row_len_cfg = 1;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_BYTES_PER_PIXEL: bpp_cfg     = cfg_wdata[BPP_W-1:0];
          REG_ROW_BYTES:       row_len_cfg = cfg_wdata[ROW_BYTES_W-1:0];
          default: ;
        endcase
      end
      if (out_mon.valid && out_mon.ready) begin
        if (recon_fifo.size() == 0) begin
          fail_count++;
          $display("%0t ns: word with none awaited, expected nothing, got recon_byte %02h row_end %0b",
                   $time, out_mon.recon_byte, out_mon.row_end);
        end else begin
          want = recon_fifo.pop_front();
          if (want.recon_byte !== out_mon.recon_byte) begin
            fail_count++;
            $display("%0t ns: recon_byte expected %02h, got %02h",
                     $time, want.recon_byte, out_mon.recon_byte);
          end
          if (want.row_end !== out_mon.row_end) begin
            fail_count++;
            $display("%0t ns: row_end expected %0b, got %0b",
                     $time, want.row_end, out_mon.row_end);
          end
        end
      end
      if (in_mon.valid && in_mon.ready)
        recon_fifo.push_back(unfilter_next(in_mon.filtered_byte, in_mon.filter_kind,
                                           in_mon.first_row));
    end
    awaited = recon_fifo.size();
  end

endmodule

// ===== dv/testbench.sv =====
// Top of the unfilter testbench: clock, reset, stimulus, result back-pressure and verdict.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import pngu_pkg::*;

  localparam int CLK_HALF     = 6;
  localparam int RESET_CYCLES = 12;
  localparam int IDLE_PCT     = 13;
  localparam int HOLD_CYCLES  = 300;
  // Settling margin that drain_block waits after the last awaited word has come back.
  localparam int DRAIN_CYCLES = 8;
  localparam int PHASE_WORDS  = 120;
  localparam int NUM_PHASES   = 12;
  // About fifteen hundred words, plus the hold-off and the drains around register
  // writes; this leaves ample margin.
  localparam int CYCLE_LIMIT  = 400000;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  int                    fail_count;
  int                    awaited;

  pngu_in_if  in_ch ();
  pngu_out_if out_ch ();

  png_scanline_unfilter_core DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  pngu_recon_checker recon_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_mon     (in_ch),
    .out_mon    (out_ch),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .fail_count (fail_count),
    .awaited    (awaited)
  );

  // Shared between the stimulus and the receiver. While calm is set neither side
  // idles. Each bump of hold_token asks the receiver for one long hold-off.
  logic calm;
  int   hold_token;

  // The stimulus side mirrors the row position and how far the line store has
  // been filled since reset, so that it never asks for an upper byte at a column
  // that no earlier row has written. Entries are always filled from column zero
  // upward, so one high-water mark is enough.
  int unsigned          gen_col;
  int unsigned          stored_upto;
  logic [ROW_BYTES_W-1:0] len_set;

  initial begin
    clk = 1'b0;
    forever begin
      #CLK_HALF clk = 1'b1;
      #CLK_HALF clk = 1'b0;
    end
  end

  // Watchdog: a hung handshake or a lost result ends the run here.
  initial begin
    int unsigned cycle_count;
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Simulation FAILED");
    $finish;
  end

  // Result side. Ready drops in about one cycle out of eight, never while calm,
  // and for a long stretch whenever the stimulus asks for a hold-off. The
  // hold-off is counted here, so the sender keeps offering words meanwhile and
  // the block has to fill up and push back on its input.
  initial begin
    int stall_left;
    int hold_seen;
    stall_left   = 0;
    hold_seen    = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_token != hold_seen) begin
        hold_seen  = hold_token;
        stall_left = HOLD_CYCLES;
      end
      if (stall_left > 0) begin
        out_ch.ready <= 1'b0;
        stall_left--;
      end else begin
        out_ch.ready <= calm || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  // Offers one word and returns at the rising edge that accepts it. The next
  // call drives at the following falling edge, so back-to-back words keep valid
  // high without a glitch. The first-row flag is forced wherever the line store
  // entry for this column has never been written.
  task automatic send_word(input logic [BYTE_W-1:0] data, input logic [KIND_W-1:0] kind,
                           input logic top);
    int unsigned len;
    int unsigned col;
    len = (len_set == 0) ? 1 : ((len_set > MAX_ROW_BYTES) ? MAX_ROW_BYTES : len_set);
    col = (gen_col >= len) ? len - 1 : gen_col;
    if (col >= stored_upto) top = 1'b1;
    if (col + 1 > stored_upto) stored_upto = col + 1;
    gen_col = (col + 1 >= len) ? 0 : col + 1;

    if (!calm && $urandom_range(99) < IDLE_PCT) begin
      @(negedge clk) in_ch.valid <= 1'b0;
    end
    @(negedge clk);
    in_ch.valid         <= 1'b1;
    in_ch.filtered_byte <= data;
    in_ch.filter_kind   <= kind;
    in_ch.first_row     <= top;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // Lowers valid and waits until every awaited word has come back, plus a margin of
  // DRAIN_CYCLES. Used before register writes, for the sender pause and at the end.
  task automatic drain_block();
    @(negedge clk) in_ch.valid <= 1'b0;
    while (awaited != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // Registers are only written with the block idle, one write per cycle.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned value);
    drain_block();
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value[CFG_DATA_W-1:0];
    @(negedge clk) cfg_we <= 1'b0;
    if (idx == REG_ROW_BYTES) len_set = value[ROW_BYTES_W-1:0];
  endtask

  initial begin
    int unsigned      phase_bpp [NUM_PHASES];
    int unsigned      phase_len [NUM_PHASES];
    logic [KIND_W-1:0] row_kind;
    logic [KIND_W-1:0] kind;
    logic             row_top;
    logic             top;
    int               sent;

    phase_bpp           = '{1, 3, 4, 8, 2, 6, 15, 0, 9, 5, 7, 8};
    phase_len           = '{5, 24, 40, 33, 7, 64, 20, 9, 12, 0, 3, 1};
    calm                = 1'b0;
    hold_token          = 0;
    gen_col             = 0;
    stored_upto         = 0;
    len_set             = 1;
    rst_n               = 1'b0;
    cfg_we              = 1'b0;
    cfg_index           = REG_BYTES_PER_PIXEL;
    cfg_wdata           = '0;
    in_ch.valid         = 1'b0;
    in_ch.filtered_byte = '0;
    in_ch.filter_kind   = FILT_NONE;
    in_ch.first_row     = 1'b1;

    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    // Directed part. Three-byte pixels on six-byte rows, so that the left
    // neighbours read as zero for the first pixel and real bytes after it.
    write_reg(REG_BYTES_PER_PIXEL, 3);
    write_reg(REG_ROW_BYTES, 6);

    // First row of an image: the upper bytes read as zero, so Paeth reduces to
    // the left byte. Byte values sweep the extremes.
    send_word(8'hFF, FILT_PAETH, 1'b1);
    send_word(8'h80, FILT_PAETH, 1'b1);
    send_word(8'h01, FILT_PAETH, 1'b1);
    send_word(8'h7F, FILT_PAETH, 1'b1);
    send_word(8'hFE, FILT_PAETH, 1'b1);
    send_word(8'h00, FILT_PAETH, 1'b1);

    // Second row: every filter code in turn, then an unknown code with all
    // bits set, which must pass the byte through unchanged.
    send_word(8'h12, FILT_NONE,  1'b0);
    send_word(8'h34, FILT_SUB,   1'b0);
    send_word(8'hFF, FILT_UP,    1'b0);
    send_word(8'hFF, FILT_AVG,   1'b0);
    send_word(8'h80, FILT_PAETH, 1'b0);
    send_word(8'h55, 8'hFF,      1'b0);

    // Third row: the flags change within the row, including a first-row flag
    // raised in the middle, and another unknown code just above Paeth.
    send_word(8'h00, FILT_AVG,   1'b0);
    send_word(8'hFF, FILT_PAETH, 1'b0);
    send_word(8'h00, FILT_PAETH, 1'b0);
    send_word(8'h01, FILT_SUB,   1'b0);
    send_word(8'h80, FILT_UP,    1'b1);
    send_word(8'h7F, FILT_PAETH + 8'd1, 1'b0);

    // Both registers get values above their range, so the pixel width
    // saturates to eight and the row length to the line store depth. A row
    // runs part way and the row length then shrinks below the current column,
    // which must end the row on the next byte.
    write_reg(REG_BYTES_PER_PIXEL, 15);
    write_reg(REG_ROW_BYTES, 16383);
    for (int i = 0; i < 24; i++)
      send_word(BYTE_W'($urandom_range(255)), KIND_W'($urandom_range(FILT_PAETH)), 1'b0);
    write_reg(REG_ROW_BYTES, 10);

    // Random part: a series of settings, each a run of rows with one filter code
    // per row and a first-row flag raised on about one row in eight. A small share
    // of the bytes carry a stray code or a flipped first-row flag, and now and then
    // a whole row uses an unknown code.
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      write_reg(REG_BYTES_PER_PIXEL, phase_bpp[ph]);
      write_reg(REG_ROW_BYTES, phase_len[ph]);
      calm     = (ph == 6);
      row_top  = 1'b1;
      row_kind = FILT_NONE;
      sent     = 0;
      while (sent < PHASE_WORDS) begin
        if (gen_col == 0) begin
          row_kind = ($urandom_range(9) == 0) ? KIND_W'($urandom_range(255))
                                              : KIND_W'($urandom_range(FILT_PAETH));
          row_top  = ($urandom_range(7) == 0);
        end
        kind = row_kind;
        top  = row_top;
        if ($urandom_range(19) == 0) kind = KIND_W'($urandom_range(255));
        if ($urandom_range(19) == 0) top = ~top;

        // Pressure: a long receiver hold-off while words keep coming, and
        // later a full pause of the sender until nothing is outstanding.
        if (ph == 3 && sent == 40) hold_token++;
        if (ph == 5 && sent == 60) drain_block();

        send_word(BYTE_W'($urandom_range(255)), kind, top);
        sent++;
      end
    end
    calm = 1'b0;

    drain_block();
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
